[hdl/gmdp_pkg.sv]
// Shared types and constants for the grid maze depth-first path search block.
package gmdp_pkg;

    localparam int COORD_W    = 3;
    localparam int DIR_W      = 3;
    localparam int ENTRY_W    = 2 * COORD_W + DIR_W;
    localparam int DIM_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Input command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_ROWS,
        CFG_GRID_COLS,
        CFG_GOAL_ROW,
        CFG_GOAL_COL
    } cfg_idx_t;

    // Next neighbor to try from a stack entry; DIR_DONE means all tried
    typedef enum logic [DIR_W-1:0] {
        DIR_DOWN,
        DIR_UP,
        DIR_RIGHT,
        DIR_LEFT,
        DIR_DONE
    } dir_t;

    // Address source for the wall store read port
    typedef enum logic [1:0] {
        RD_GOAL,
        RD_START,
        RD_NEIGHBOR
    } wall_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GOAL_RD,
        ST_GOAL_CHK,
        ST_START_CHK,
        ST_STEP,
        ST_NB_CHK,
        ST_POP,
        ST_EMIT_RD,
        ST_EMIT,
        ST_MISS
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic      wall_wr;
        logic      search_init;
        wall_sel_t wall_sel;
        logic      start_push;
        logic      dir_adv;
        logic      push;
        logic      pop_rd;
        logic      pop_load;
        logic      emit_init;
        logic      emit_out;
        logic      miss_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic goal_bad;
        logic wall_hit;
        logic goal_at_start;
        logic top_done;
        logic depth_one;
        logic nb_blocked;
        logic nb_goal;
        logic emit_top;
    } dp_status_t;

endpackage

[hdl/grid_maze_dfs_path.sv]
// Top level of the grid maze depth-first path search block.
// Load commands are taken while idle and can come back to back; no result is produced.
// A search holds busy through setup: goal read, goal check, start check (a miss after the goal
// check when the goal is off the grid or a wall). Each direction tried takes a step, then a wall
// check if on the grid and unvisited; a backtrack adds a pop; the end emits the path or a miss.
// Results appear one per cycle, in the cycle after their state; the receiver cannot stall.
// rst_n clears all control and the wall valid bits: every cell reads open, registers reload.
module grid_maze_dfs_path
#(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cmd,
    input  logic [gmdp_pkg::COORD_W-1:0]        cell_row,
    input  logic [gmdp_pkg::COORD_W-1:0]        cell_col,
    input  logic                                cell_wall,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gmdp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gmdp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                strobe,
    output logic                                found,
    output logic [gmdp_pkg::COORD_W-1:0]        path_row,
    output logic [gmdp_pkg::COORD_W-1:0]        path_col,
    output logic                                last
);

    gmdp_pkg::ctrl_cmd_t  ctrl;
    gmdp_pkg::dp_status_t status;

    // Configuration is always taken
    assign cfg_ready = 1'b1;

    gmdp_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    gmdp_dp
    #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .status    (status),
        .cell_row  (cell_row),
        .cell_col  (cell_col),
        .cell_wall (cell_wall),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .strobe    (strobe),
        .found     (found),
        .path_row  (path_row),
        .path_col  (path_col),
        .last      (last)
    );

endmodule

[hdl/gmdp_ctrl.sv]
// Controller state machine sequencing load, search, backtrack and path emission.
module gmdp_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  cmd,
    input  gmdp_pkg::dp_status_t  status,
    output gmdp_pkg::ctrl_cmd_t   ctrl,
    output logic                  busy
);

    gmdp_pkg::state_t state_reg;
    gmdp_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gmdp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gmdp_pkg::ST_IDLE:
            begin
                if (start && (cmd == gmdp_pkg::CMD_SEARCH))
                begin
                    state_next = gmdp_pkg::ST_GOAL_RD;
                end
            end
            gmdp_pkg::ST_GOAL_RD:
            begin
                state_next = gmdp_pkg::ST_GOAL_CHK;
            end
            gmdp_pkg::ST_GOAL_CHK:
            begin
                state_next = status.goal_bad ? gmdp_pkg::ST_MISS : gmdp_pkg::ST_START_CHK;
            end
            gmdp_pkg::ST_START_CHK:
            begin
                priority if (status.wall_hit)
                begin
                    state_next = gmdp_pkg::ST_MISS;
                end
                else if (status.goal_at_start)
                begin
                    state_next = gmdp_pkg::ST_EMIT_RD;
                end
                else
                begin
                    state_next = gmdp_pkg::ST_STEP;
                end
            end
            gmdp_pkg::ST_STEP:
            begin
                priority if (status.top_done && status.depth_one)
                begin
                    state_next = gmdp_pkg::ST_MISS;
                end
                else if (status.top_done)
                begin
                    state_next = gmdp_pkg::ST_POP;
                end
                else if (status.nb_blocked)
                begin
                    state_next = gmdp_pkg::ST_STEP;
                end
                else
                begin
                    state_next = gmdp_pkg::ST_NB_CHK;
                end
            end
            gmdp_pkg::ST_NB_CHK:
            begin
                priority if (status.wall_hit)
                begin
                    state_next = gmdp_pkg::ST_STEP;
                end
                else if (status.nb_goal)
                begin
                    state_next = gmdp_pkg::ST_EMIT_RD;
                end
                else
                begin
                    state_next = gmdp_pkg::ST_STEP;
                end
            end
            gmdp_pkg::ST_POP:
            begin
                state_next = gmdp_pkg::ST_STEP;
            end
            gmdp_pkg::ST_EMIT_RD:
            begin
                state_next = gmdp_pkg::ST_EMIT;
            end
            gmdp_pkg::ST_EMIT:
            begin
                if (status.emit_top)
                begin
                    state_next = gmdp_pkg::ST_IDLE;
                end
            end
            gmdp_pkg::ST_MISS:
            begin
                state_next = gmdp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gmdp_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        ctrl          = '0;
        ctrl.wall_sel = gmdp_pkg::RD_NEIGHBOR;
        busy          = 1'b1;
        unique case (state_reg)
            gmdp_pkg::ST_IDLE:
            begin
                busy             = 1'b0;
                ctrl.wall_wr     = start && (cmd == gmdp_pkg::CMD_LOAD);
                ctrl.search_init = start && (cmd == gmdp_pkg::CMD_SEARCH);
            end
            gmdp_pkg::ST_GOAL_RD:
            begin
                ctrl.wall_sel = gmdp_pkg::RD_GOAL;
            end
            gmdp_pkg::ST_GOAL_CHK:
            begin
                ctrl.wall_sel = gmdp_pkg::RD_START;
            end
            gmdp_pkg::ST_START_CHK:
            begin
                ctrl.start_push = !status.wall_hit;
                ctrl.emit_init  = !status.wall_hit && status.goal_at_start;
            end
            gmdp_pkg::ST_STEP:
            begin
                ctrl.dir_adv = !status.top_done;
                ctrl.pop_rd  = status.top_done;
            end
            gmdp_pkg::ST_NB_CHK:
            begin
                ctrl.push      = !status.wall_hit;
                ctrl.emit_init = !status.wall_hit && status.nb_goal;
            end
            gmdp_pkg::ST_POP:
            begin
                ctrl.pop_load = 1'b1;
            end
            gmdp_pkg::ST_EMIT_RD:
            begin
                ctrl.emit_init = 1'b1;
            end
            gmdp_pkg::ST_EMIT:
            begin
                ctrl.emit_out = 1'b1;
            end
            gmdp_pkg::ST_MISS:
            begin
                ctrl.miss_out = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

[hdl/gmdp_dp.sv]
// Datapath: configuration, wall store, visited map, search stack and result registers.
module gmdp_dp
#(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  gmdp_pkg::ctrl_cmd_t                 ctrl,
    output gmdp_pkg::dp_status_t                status,
    input  logic [gmdp_pkg::COORD_W-1:0]        cell_row,
    input  logic [gmdp_pkg::COORD_W-1:0]        cell_col,
    input  logic                                cell_wall,
    input  logic                                cfg_wr,
    input  logic [gmdp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gmdp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                strobe,
    output logic                                found,
    output logic [gmdp_pkg::COORD_W-1:0]        path_row,
    output logic [gmdp_pkg::COORD_W-1:0]        path_col,
    output logic                                last
);

    localparam int CELLS   = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int DEPTH_W = $clog2(CELLS + 1);
    localparam int CW      = gmdp_pkg::COORD_W;
    localparam int DW      = gmdp_pkg::DIM_W;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [CW-1:0] r,
                                                    input logic [CW-1:0] c);
        cell_addr = ADDR_W'(int'(r) * MAX_COLS + int'(c));
    endfunction

    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v,
                                                input logic [DW-1:0] maxv);
        logic [DW-1:0] res;
        res = v;
        if (v == '0)
        begin
            res = DW'(1);
        end
        else if (v > maxv)
        begin
            res = maxv;
        end
        clamp_dim = res;
    endfunction

    // Configuration registers
    logic [DW-1:0]  grid_rows_reg;
    logic [DW-1:0]  grid_cols_reg;
    logic [CW-1:0]  goal_row_reg;
    logic [CW-1:0]  goal_col_reg;

    // Search registers
    logic [DW-1:0]          use_rows_reg;
    logic [DW-1:0]          use_cols_reg;
    logic [CELLS-1:0]       wall_vld_reg;
    logic [CELLS-1:0]       visited_reg;
    logic                   wall_q_reg;
    logic                   wall_vq_reg;
    logic [CW-1:0]          top_row_reg;
    logic [CW-1:0]          top_col_reg;
    gmdp_pkg::dir_t         top_dir_reg;
    logic [CW-1:0]          nb_row_reg;
    logic [CW-1:0]          nb_col_reg;
    logic [ADDR_W-1:0]      nb_addr_reg;
    logic [DEPTH_W-1:0]     depth_reg;
    logic [DEPTH_W-1:0]     k_reg;
    logic [gmdp_pkg::ENTRY_W-1:0] stk_q_reg;

    // Result registers
    logic           strobe_reg;
    logic           found_reg;
    logic [CW-1:0]  path_row_reg;
    logic [CW-1:0]  path_col_reg;
    logic           last_reg;

    // Memories
    logic                          wall_mem [CELLS];
    logic [gmdp_pkg::ENTRY_W-1:0]  stk_mem  [CELLS];

    logic [DW-1:0]      nb_r;
    logic [DW-1:0]      nb_c;
    logic               nb_under;
    logic               nb_off;
    logic [ADDR_W-1:0]  nb_addr;
    logic [ADDR_W-1:0]  wall_raddr;
    logic [ADDR_W-1:0]  load_addr;
    logic               load_ok;
    logic               wall_eff;
    logic               goal_off;
    logic [DEPTH_W-1:0] depth_m1;
    logic [DEPTH_W-1:0] stk_raddr;

    // Neighbor for the direction at the top of the stack
    always_comb
    begin
        nb_r     = {1'b0, top_row_reg};
        nb_c     = {1'b0, top_col_reg};
        nb_under = 1'b0;
        unique case (top_dir_reg)
            gmdp_pkg::DIR_DOWN:
            begin
                nb_r = {1'b0, top_row_reg} + DW'(1);
            end
            gmdp_pkg::DIR_UP:
            begin
                nb_r     = {1'b0, top_row_reg} - DW'(1);
                nb_under = (top_row_reg == '0);
            end
            gmdp_pkg::DIR_RIGHT:
            begin
                nb_c = {1'b0, top_col_reg} + DW'(1);
            end
            gmdp_pkg::DIR_LEFT:
            begin
                nb_c     = {1'b0, top_col_reg} - DW'(1);
                nb_under = (top_col_reg == '0);
            end
            default:
            begin
                nb_under = 1'b1;
            end
        endcase
    end

    assign nb_off    = nb_under || (nb_r >= use_rows_reg) || (nb_c >= use_cols_reg);
    assign nb_addr   = cell_addr(nb_r[CW-1:0], nb_c[CW-1:0]);
    assign load_addr = cell_addr(cell_row, cell_col);
    assign load_ok   = (int'(cell_row) < MAX_ROWS) && (int'(cell_col) < MAX_COLS);
    assign wall_eff  = wall_q_reg && wall_vq_reg;
    assign goal_off  = ({1'b0, goal_row_reg} >= use_rows_reg)
                    || ({1'b0, goal_col_reg} >= use_cols_reg);
    assign depth_m1  = depth_reg - DEPTH_W'(1);

    // Wall read address
    always_comb
    begin
        unique case (ctrl.wall_sel)
            gmdp_pkg::RD_GOAL:     wall_raddr = cell_addr(goal_row_reg, goal_col_reg);
            gmdp_pkg::RD_START:    wall_raddr = '0;
            gmdp_pkg::RD_NEIGHBOR: wall_raddr = nb_addr;
            default:               wall_raddr = '0;
        endcase
    end

    // Stack read address: entry below the top on a pop, else the emit index
    always_comb
    begin
        priority if (ctrl.pop_rd)
        begin
            stk_raddr = depth_reg - DEPTH_W'(2);
        end
        else if (ctrl.emit_init)
        begin
            stk_raddr = '0;
        end
        else
        begin
            stk_raddr = k_reg + DEPTH_W'(1);
        end
    end

    // Status
    always_comb
    begin
        status               = '0;
        status.goal_bad      = goal_off || wall_eff;
        status.wall_hit      = wall_eff;
        status.goal_at_start = (goal_row_reg == '0) && (goal_col_reg == '0);
        status.top_done      = (top_dir_reg == gmdp_pkg::DIR_DONE);
        status.depth_one     = (depth_reg == DEPTH_W'(1));
        status.nb_blocked    = nb_off ? 1'b1 : visited_reg[nb_addr];
        status.nb_goal       = (nb_row_reg == goal_row_reg) && (nb_col_reg == goal_col_reg);
        status.emit_top      = (k_reg == depth_m1);
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= DW'(8);
            grid_cols_reg <= DW'(8);
            goal_row_reg  <= '0;
            goal_col_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (gmdp_pkg::cfg_idx_t'(cfg_index))
                gmdp_pkg::CFG_GRID_ROWS: grid_rows_reg <= cfg_data;
                gmdp_pkg::CFG_GRID_COLS: grid_cols_reg <= cfg_data;
                gmdp_pkg::CFG_GOAL_ROW:  goal_row_reg  <= cfg_data[CW-1:0];
                gmdp_pkg::CFG_GOAL_COL:  goal_col_reg  <= cfg_data[CW-1:0];
            endcase
        end
    end

    // Wall store: write on load, registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.wall_wr && load_ok)
        begin
            wall_mem[load_addr] <= cell_wall;
        end
        wall_q_reg <= wall_mem[wall_raddr];
    end

    // Wall valid bits: unwritten cells read as open
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_vld_reg <= '0;
            wall_vq_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.wall_wr && load_ok)
            begin
                wall_vld_reg[load_addr] <= 1'b1;
            end
            wall_vq_reg <= wall_vld_reg[wall_raddr];
        end
    end

    // Stack store: push saves the old top, registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            stk_mem[depth_m1[ADDR_W-1:0]] <= {top_row_reg, top_col_reg, top_dir_reg};
        end
        stk_q_reg <= stk_mem[stk_raddr[ADDR_W-1:0]];
    end

    // Visited map and stack depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg  <= '0;
            depth_reg    <= '0;
            k_reg        <= '0;
            use_rows_reg <= DW'(1);
            use_cols_reg <= DW'(1);
        end
        else
        begin
            if (ctrl.search_init)
            begin
                visited_reg  <= '0;
                depth_reg    <= '0;
                use_rows_reg <= clamp_dim(grid_rows_reg, DW'(MAX_ROWS));
                use_cols_reg <= clamp_dim(grid_cols_reg, DW'(MAX_COLS));
            end
            if (ctrl.start_push)
            begin
                visited_reg[0] <= 1'b1;
                depth_reg      <= DEPTH_W'(1);
            end
            if (ctrl.push)
            begin
                visited_reg[nb_addr_reg] <= 1'b1;
                depth_reg                <= depth_reg + DEPTH_W'(1);
            end
            if (ctrl.pop_rd)
            begin
                depth_reg <= depth_m1;
            end
            if (ctrl.emit_init)
            begin
                k_reg <= '0;
            end
            else if (ctrl.emit_out)
            begin
                k_reg <= k_reg + DEPTH_W'(1);
            end
        end
    end

    // Top of stack and latched neighbor
    always_ff @(posedge clk)
    begin
        priority if (ctrl.start_push)
        begin
            top_row_reg <= '0;
            top_col_reg <= '0;
            top_dir_reg <= gmdp_pkg::DIR_DOWN;
        end
        else if (ctrl.push)
        begin
            top_row_reg <= nb_row_reg;
            top_col_reg <= nb_col_reg;
            top_dir_reg <= gmdp_pkg::DIR_DOWN;
        end
        else if (ctrl.pop_load)
        begin
            top_row_reg <= stk_q_reg[gmdp_pkg::ENTRY_W-1 -: CW];
            top_col_reg <= stk_q_reg[gmdp_pkg::DIR_W +: CW];
            top_dir_reg <= gmdp_pkg::dir_t'(stk_q_reg[gmdp_pkg::DIR_W-1:0]);
        end
        else if (ctrl.dir_adv)
        begin
            top_dir_reg <= gmdp_pkg::dir_t'(top_dir_reg + gmdp_pkg::DIR_W'(1));
        end
        if (ctrl.dir_adv)
        begin
            nb_row_reg  <= nb_r[CW-1:0];
            nb_col_reg  <= nb_c[CW-1:0];
            nb_addr_reg <= nb_addr;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= ctrl.emit_out || ctrl.miss_out;
        end
    end

    // Result payload: stack entries bottom up, the top from its registers
    always_ff @(posedge clk)
    begin
        found_reg <= ctrl.emit_out;
        last_reg  <= ctrl.miss_out || status.emit_top;
        priority if (ctrl.miss_out)
        begin
            path_row_reg <= '0;
            path_col_reg <= '0;
        end
        else if (status.emit_top)
        begin
            path_row_reg <= top_row_reg;
            path_col_reg <= top_col_reg;
        end
        else
        begin
            path_row_reg <= stk_q_reg[gmdp_pkg::ENTRY_W-1 -: CW];
            path_col_reg <= stk_q_reg[gmdp_pkg::DIR_W +: CW];
        end
    end

    assign strobe   = strobe_reg;
    assign found    = found_reg;
    assign path_row = path_row_reg;
    assign path_col = path_col_reg;
    assign last     = last_reg;

endmodule

[hdl/gmdp_checker.sv]
// Port-level checker for the grid maze path search, bound to the top level.
module gmdp_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                cmd,
    input logic                                strobe,
    input logic                                found,
    input logic [gmdp_pkg::COORD_W-1:0]        path_row,
    input logic [gmdp_pkg::COORD_W-1:0]        path_col,
    input logic                                last
);

    // A search transaction keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd |=> busy)
        else $error("search transaction did not raise busy");

    // A miss is a single final result with zero coordinates
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !found |-> last && path_row == '0 && path_col == '0)
        else $error("miss result malformed");

    // Path cells stream without gaps until the last one
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && found && !last |=> strobe && found)
        else $error("gap or miss inside a path stream");

    // Nothing follows the final result directly
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("result after the final one");

endmodule

bind grid_maze_dfs_path gmdp_checker u_gmdp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .strobe   (strobe),
    .found    (found),
    .path_row (path_row),
    .path_col (path_col),
    .last     (last)
);

[tb/sv/grid_maze_dfs_path_test.sv]
// Self-checking testbench for the grid maze depth-first path search block.
`timescale 1ns / 100ps

module grid_maze_dfs_path_test;

    import gmdp_pkg::*;

    localparam int GRID_MAX    = 8;
    localparam int CELL_COUNT  = GRID_MAX * GRID_MAX;
    localparam int ITEM_TARGET = 400;
    localparam int SETTLE_CYC  = 8;
    localparam int DRAIN_LIMIT = 200000;
    localparam int TIMEOUT_NS  = 10_000_000;

    // Kinds of work the driver carries out, in queue order
    typedef enum logic [1:0] {
        OP_ITEM,
        OP_CFG,
        OP_DRAIN
    } op_kind_t;

    typedef struct {
        op_kind_t              kind;
        logic                  cmd;
        logic [COORD_W-1:0]    row;
        logic [COORD_W-1:0]    col;
        logic                  wall;
        cfg_idx_t              idx;
        logic [CFG_DATA_W-1:0] data;
    } maze_op_t;

    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } path_cell_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    logic                  cmd       = CMD_LOAD;
    logic [COORD_W-1:0]    cell_row  = '0;
    logic [COORD_W-1:0]    cell_col  = '0;
    logic                  cell_wall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  strobe;
    logic                  found;
    logic [COORD_W-1:0]    path_row;
    logic [COORD_W-1:0]    path_col;
    logic                  last;

    // Shadow copy of the maze store and the registers
    logic                  maze_wall [GRID_MAX][GRID_MAX] = '{default: 1'b0};
    logic [DIM_W-1:0]      rows_reg     = 4'd8;
    logic [DIM_W-1:0]      cols_reg     = 4'd8;
    logic [COORD_W-1:0]    goal_row_reg = '0;
    logic [COORD_W-1:0]    goal_col_reg = '0;

    maze_op_t              op_q [$];
    path_cell_t            path_q [$];

    maze_op_t              cur_op;
    bit                    op_busy      = 1'b0;
    bit                    item_taken   = 1'b0;
    bit                    cfg_taken    = 1'b0;
    int                    burst_left   = 1;
    int                    gap_left     = 0;
    int                    settle_left  = 0;
    int                    cmd_count    = 0;
    int                    mismatch_cnt = 0;

    grid_maze_dfs_path i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .cell_row  (cell_row),
        .cell_col  (cell_col),
        .cell_wall (cell_wall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .strobe    (strobe),
        .found     (found),
        .path_row  (path_row),
        .path_col  (path_col),
        .last      (last)
    );

    // Free-running clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hold reset for the opening cycles, release on a falling edge
    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int clamp_dim(input int v);
        if (v < 1)
            return 1;
        if (v > GRID_MAX)
            return GRID_MAX;
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [COORD_W-1:0] got,
                               input logic [COORD_W-1:0] want_v);
        if (got !== want_v)
            report_mismatch($sformatf("%s is %0d, wanted %0d", name, got, want_v));
    endtask

    // Walk the shadow maze depth first and queue the path cells it yields
    function automatic void predict_search();
        int                 rows;
        int                 cols;
        int                 gr;
        int                 gc;
        int                 depth;
        int                 top;
        int                 nr;
        int                 nc;
        bit                 hit;
        dir_t               d;
        logic [COORD_W-1:0] stk_r [CELL_COUNT];
        logic [COORD_W-1:0] stk_c [CELL_COUNT];
        dir_t               stk_d [CELL_COUNT];
        bit                 seen [GRID_MAX][GRID_MAX];
        path_cell_t         pc;

        rows  = clamp_dim(int'(rows_reg));
        cols  = clamp_dim(int'(cols_reg));
        gr    = int'(goal_row_reg);
        gc    = int'(goal_col_reg);
        seen  = '{default: 1'b0};
        hit   = 1'b0;
        depth = 0;
        if (gr < rows && gc < cols && !maze_wall[gr][gc] && !maze_wall[0][0])
        begin
            seen[0][0] = 1'b1;
            stk_r[0]   = '0;
            stk_c[0]   = '0;
            stk_d[0]   = DIR_DOWN;
            depth      = 1;
            hit        = (gr == 0 && gc == 0);
            while (!hit && depth > 0)
            begin
                top = depth - 1;
                // Every neighbor tried: backtrack
                if (stk_d[top] == DIR_DONE)
                begin
                    depth--;
                    continue;
                end
                d          = stk_d[top];
                stk_d[top] = dir_t'(d + 1);
                nr         = int'(stk_r[top]);
                nc         = int'(stk_c[top]);
                case (d)
                    DIR_DOWN:  nr = nr + 1;
                    DIR_UP:    nr = nr - 1;
                    DIR_RIGHT: nc = nc + 1;
                    default:   nc = nc - 1;
                endcase
                if (nr < 0 || nc < 0 || nr >= rows || nc >= cols)
                    continue;
                if (maze_wall[nr][nc] || seen[nr][nc] || depth >= CELL_COUNT)
                    continue;
                // Advance into the open neighbor
                seen[nr][nc] = 1'b1;
                stk_r[depth] = nr[COORD_W-1:0];
                stk_c[depth] = nc[COORD_W-1:0];
                stk_d[depth] = DIR_DOWN;
                depth++;
                hit = (nr == gr && nc == gc);
            end
        end
        if (hit)
        begin
            for (int k = 0; k < depth; k++)
            begin
                pc.found = 1'b1;
                pc.row   = stk_r[k];
                pc.col   = stk_c[k];
                pc.last  = (k == depth - 1);
                path_q   = {path_q, pc};
            end
        end
        else
        begin
            pc.found = 1'b0;
            pc.row   = '0;
            pc.col   = '0;
            pc.last  = 1'b1;
            path_q   = {path_q, pc};
        end
    endfunction

    // Driver operation of the given kind with every other field cleared
    function automatic maze_op_t blank_op(input op_kind_t kind);
        maze_op_t op;

        op.kind = kind;
        op.cmd  = CMD_LOAD;
        op.row  = '0;
        op.col  = '0;
        op.wall = 1'b0;
        op.idx  = CFG_GRID_ROWS;
        op.data = '0;
        return op;
    endfunction

    function automatic void push_item(input logic c, input int r, input int col, input logic w);
        maze_op_t op;

        op      = blank_op(OP_ITEM);
        op.cmd  = c;
        op.row  = r[COORD_W-1:0];
        op.col  = col[COORD_W-1:0];
        op.wall = w;
        op_q    = {op_q, op};
        cmd_count++;
    endfunction

    function automatic void push_load(input int r, input int c, input logic w);
        push_item(CMD_LOAD, r, c, w);
    endfunction

    // Search with random don't-care cell fields
    function automatic void push_search();
        push_item(CMD_SEARCH, $urandom_range(0, 7), $urandom_range(0, 7),
                  1'($urandom_range(0, 1)));
    endfunction

    function automatic void push_cfg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] v);
        maze_op_t op;

        op      = blank_op(OP_CFG);
        op.idx  = idx;
        op.data = v;
        op_q    = {op_q, op};
    endfunction

    // Wait for the block to go quiet, then rewrite all four registers
    function automatic void push_settings(input int r, input int c, input int gr, input int gc);
        maze_op_t op;

        op   = blank_op(OP_DRAIN);
        op_q = {op_q, op};
        push_cfg(CFG_GRID_ROWS, r[CFG_DATA_W-1:0]);
        push_cfg(CFG_GRID_COLS, c[CFG_DATA_W-1:0]);
        push_cfg(CFG_GOAL_ROW, {1'($urandom_range(0, 1)), gr[COORD_W-1:0]});
        push_cfg(CFG_GOAL_COL, {1'($urandom_range(0, 1)), gc[COORD_W-1:0]});
    endfunction

    // Mostly sizes in range, now and then zero or above the maximum
    function automatic int pick_dim();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? 0 : $urandom_range(GRID_MAX + 1, 15);
        return $urandom_range(1, GRID_MAX);
    endfunction

    function automatic int pick_goal(input int dim);
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(0, GRID_MAX - 1);
        return $urandom_range(0, clamp_dim(dim) - 1);
    endfunction

    // Driver: present queued transactions on the falling edge
    always @(negedge clk)
    begin
        logic nx_start;
        logic nx_cfg;

        nx_start = 1'b0;
        nx_cfg   = 1'b0;
        if (rst_n)
        begin
            // Retire the transaction accepted at the last rising edge
            if (item_taken || cfg_taken)
                op_busy = 1'b0;
            if (item_taken)
            begin
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (!op_busy && op_q.size() > 0)
            begin
                cur_op      = op_q.pop_front();
                op_busy     = 1'b1;
                settle_left = SETTLE_CYC;
            end
            if (op_busy)
            begin
                case (cur_op.kind)
                    OP_ITEM:
                    begin
                        if (gap_left > 0)
                            gap_left--;
                        else
                            nx_start = 1'b1;
                    end
                    OP_CFG:
                        nx_cfg = 1'b1;
                    default:
                    begin
                        // Hold until every result is in and the block has settled
                        if (path_q.size() == 0 && !busy)
                        begin
                            if (settle_left == 0)
                                op_busy = 1'b0;
                            else
                                settle_left--;
                        end
                    end
                endcase
            end
        end
        start     <= nx_start;
        cfg_valid <= nx_cfg;
        if (nx_start)
        begin
            cmd       <= cur_op.cmd;
            cell_row  <= cur_op.row;
            cell_col  <= cur_op.col;
            cell_wall <= cur_op.wall;
        end
        else
        begin
            cmd       <= 1'($urandom_range(0, 1));
            cell_row  <= 3'($urandom_range(0, 7));
            cell_col  <= 3'($urandom_range(0, 7));
            cell_wall <= 1'($urandom_range(0, 1));
        end
        if (nx_cfg)
        begin
            cfg_index <= cur_op.idx;
            cfg_data  <= cur_op.data;
        end
        else
        begin
            cfg_index <= 2'($urandom_range(0, 3));
            cfg_data  <= 4'($urandom_range(0, 15));
        end
    end

    // Monitor: track accepted transactions and check results on the rising edge
    always @(posedge clk)
    begin
        path_cell_t want;

        item_taken <= rst_n && start && !busy;
        cfg_taken  <= rst_n && cfg_valid && cfg_ready;
        if (rst_n)
        begin
            // Update the shadow registers
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_GRID_ROWS: rows_reg     = cfg_data;
                    CFG_GRID_COLS: cols_reg     = cfg_data;
                    CFG_GOAL_ROW:  goal_row_reg = cfg_data[COORD_W-1:0];
                    default:       goal_col_reg = cfg_data[COORD_W-1:0];
                endcase
            end
            // Apply the accepted command
            if (start && !busy)
            begin
                if (cmd == CMD_LOAD)
                    maze_wall[cell_row][cell_col] = cell_wall;
                else
                    predict_search();
            end
            // Compare the strobed result with the oldest expected cell
            if (strobe)
            begin
                if (path_q.size() == 0)
                begin
                    report_mismatch("result strobed with no path cell pending");
                end
                else
                begin
                    want = path_q.pop_front();
                    check_field("found", {2'b00, found}, {2'b00, want.found});
                    check_field("path_row", path_row, want.row);
                    check_field("path_col", path_col, want.col);
                    check_field("last", {2'b00, last}, {2'b00, want.last});
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int rows;
        int cols;
        int wall_pct;
        int r;
        int c;
        int w;

        // Goal equals start at reset settings
        push_search();
        // Goal is a wall
        push_load(7, 7, 1'b1);
        push_settings(8, 8, 7, 7);
        push_search();
        // Fully open grid, longest walk to the far corner
        push_load(7, 7, 1'b0);
        push_search();
        // Start cell is a wall
        push_load(0, 0, 1'b1);
        push_settings(8, 8, 3, 3);
        push_search();
        push_load(0, 0, 1'b0);
        // Goal off the grid, by row and by column
        push_settings(4, 4, 5, 1);
        push_search();
        push_settings(8, 3, 0, 6);
        push_search();
        // Sizes of zero and above the maximum
        push_settings(0, 0, 0, 0);
        push_search();
        push_settings(15, 15, 7, 7);
        push_search();
        // Goal boxed in by walls: unreachable
        push_settings(8, 8, 2, 2);
        push_load(1, 2, 1'b1);
        push_load(3, 2, 1'b1);
        push_load(2, 1, 1'b1);
        push_load(2, 3, 1'b1);
        push_search();
        push_load(1, 2, 1'b0);
        push_load(3, 2, 1'b0);
        push_load(2, 1, 1'b0);
        push_load(2, 3, 1'b0);
        // Single-row corridor
        push_settings(1, 8, 0, 7);
        push_search();

        // Random phases: new settings, then loads interleaved with searches
        while (cmd_count < ITEM_TARGET)
        begin
            rows     = pick_dim();
            cols     = pick_dim();
            wall_pct = $urandom_range(0, 40);
            push_settings(rows, cols, pick_goal(rows), pick_goal(cols));
            repeat ($urandom_range(1, 4))
            begin
                repeat ($urandom_range(0, 12))
                begin
                    r = $urandom_range(0, 7);
                    c = $urandom_range(0, 7);
                    w = ($urandom_range(0, 99) < wall_pct);
                    // Walling in the start cell is kept rare
                    if (r == 0 && c == 0 && w != 0 && $urandom_range(0, 3) != 0)
                        w = 0;
                    push_load(r, c, 1'(w));
                end
                push_search();
            end
        end

        // Drain the driver, then the outstanding path cells
        while (op_q.size() != 0 || op_busy)
            @(posedge clk);
        for (int i = 0; i < DRAIN_LIMIT && path_q.size() != 0; i++)
            @(posedge clk);
        repeat (SETTLE_CYC * 8) @(posedge clk);
        if (path_q.size() != 0)
            report_mismatch($sformatf("%0d path cells never arrived", path_q.size()));

        if (mismatch_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
